// ----- src/sam_pkg.sv -----
// package: command codes and controller state type for the suffix automaton core
package sam_pkg;

  // input command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_W1_RD,
    S_W1_CHK,
    S_U_CHK,
    S_CP,
    S_U_LINK,
    S_W2_RD,
    S_W2_CHK,
    S_FIN,
    S_Q_CHK
  } sam_state_t;

endpackage

// ----- src/sam_store.sv -----
// module: transition memory and node memory (suffix link, path length)
module sam_store #(
  parameter int AW = 16,
  parameter int SW = 12,
  parameter int IW = 11,
  parameter int NW = 23
) (
  input  logic          clk,
  input  logic          trans_we,
  input  logic [AW-1:0] trans_waddr,
  input  logic [SW-1:0] trans_wdata,
  input  logic [AW-1:0] trans_raddr,
  output logic [SW-1:0] trans_q,
  input  logic          node_we,
  input  logic [IW-1:0] node_waddr,
  input  logic [NW-1:0] node_wdata,
  input  logic [IW-1:0] node_raddr,
  output logic [NW-1:0] node_q
);

  logic [SW-1:0] trans_mem [2**AW];
  logic [NW-1:0] node_mem  [2**IW];

  // transition table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= trans_wdata;
    end
    trans_q <= trans_mem[trans_raddr];
  end

  // node table
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

endmodule

// ----- src/suffix_automaton_substring_query_core.sv -----
// top level: suffix automaton builder and substring query controller
//
//  channel | signals                        | transfer
//  --------+--------------------------------+------------------------------
//  input   | start, cmd, symbol, last, busy | start high while busy low
//  result  | done, found, overflow          | done high for one cycle
//
// a query letter is checked in S_Q_CHK, which registers its result.
// an append clears the new state's row, then walks the suffix links, reading
// and checking each state; where the walk stops on an existing transition it
// checks the target's length. a clone copies the target's row and redirects
// transitions on a second walk (row clear and row copy share one transition
// memory port). a clear rewrites the root row; after reset the same root
// setup runs before busy falls. results cannot be held off by the receiver.
module suffix_automaton_substring_query_core #(
  parameter int MAX_TEXT = 1024,
  parameter int ALPHABET = 26
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [4:0] symbol,
  input  logic       last,
  output logic       done,
  output logic       found,
  output logic       overflow
);
  import sam_pkg::*;

  localparam int NSTATE = 2 * MAX_TEXT;
  localparam int IW     = $clog2(NSTATE);
  localparam int SW     = $clog2(NSTATE + 1);
  localparam int LW     = $clog2(MAX_TEXT + 1);
  localparam int CHW    = $clog2(ALPHABET);
  localparam int CW     = $clog2(ALPHABET + 1);
  localparam int AW     = IW + CHW;
  localparam int NW     = SW + LW;
  localparam logic [SW-1:0] NO_EDGE = SW'(NSTATE);

  sam_state_t state, state_next;
  sam_state_t clr_ret;
  logic [IW-1:0]  clr_row;
  logic [CW-1:0]  idx;
  logic [SW-1:0]  count;
  logic [IW-1:0]  last_st, cur, v, u, cl, cursor;
  logic [LW-1:0]  last_len, vlen, ulen;
  logic [SW-1:0]  link_cur;
  logic [CHW-1:0] ch;
  logic           qmiss, qbad, qfin, ovf;

  logic          trans_we, node_we;
  logic [AW-1:0] trans_waddr, trans_raddr;
  logic [SW-1:0] trans_wdata, trans_q;
  logic [IW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata, node_q;

  logic          accept;
  logic          sym_ok;
  logic [SW-1:0] nd_link;
  logic [LW-1:0] nd_len;
  logic [LW-1:0] vlen_inc, cur_len;
  logic [CHW-1:0] idx_lo, idx_m1;
  logic          miss_next;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign sym_ok   = (int'(symbol) < ALPHABET);
  assign nd_link  = node_q[NW-1:LW];
  assign nd_len   = node_q[LW-1:0];
  assign vlen_inc = LW'(vlen + 1'b1);
  assign cur_len  = LW'(last_len + 1'b1);
  assign idx_lo   = idx[CHW-1:0];
  assign idx_m1   = CHW'(idx - 1'b1);
  assign miss_next = qmiss || qbad || (trans_q == NO_EDGE);

  sam_store #(.AW(AW), .SW(SW), .IW(IW), .NW(NW)) u_store (
    .clk        (clk),
    .trans_we   (trans_we),
    .trans_waddr(trans_waddr),
    .trans_wdata(trans_wdata),
    .trans_raddr(trans_raddr),
    .trans_q    (trans_q),
    .node_we    (node_we),
    .node_waddr (node_waddr),
    .node_wdata (node_wdata),
    .node_raddr (node_raddr),
    .node_q     (node_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: state_next = S_CLR;
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_CLEAR: state_next = S_CLR;
            CMD_APPEND: begin
              if (sym_ok && !(last_len >= LW'(MAX_TEXT))) state_next = S_CLR;
            end
            CMD_QUERY: state_next = S_Q_CHK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        if (idx == CW'(ALPHABET - 1)) state_next = clr_ret;
      end
      S_W1_RD: state_next = S_W1_CHK;
      S_W1_CHK: begin
        if (trans_q == NO_EDGE) begin
          state_next = (nd_link == NO_EDGE) ? S_FIN : S_W1_RD;
        end else begin
          state_next = S_U_CHK;
        end
      end
      S_U_CHK: state_next = (nd_len == vlen_inc) ? S_FIN : S_CP;
      S_CP: begin
        if (idx == CW'(ALPHABET)) state_next = S_U_LINK;
      end
      S_U_LINK: state_next = S_W2_RD;
      S_W2_RD: state_next = S_W2_CHK;
      S_W2_CHK: begin
        if (trans_q == SW'(u) && nd_link != NO_EDGE) state_next = S_W2_RD;
        else state_next = S_FIN;
      end
      S_FIN: state_next = S_IDLE;
      S_Q_CHK: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    trans_we    = 1'b0;
    trans_waddr = '0;
    trans_wdata = NO_EDGE;
    trans_raddr = '0;
    node_we     = 1'b0;
    node_waddr  = '0;
    node_wdata  = '0;
    node_raddr  = '0;
    case (state)
      S_INIT: begin
        node_we    = 1'b1;
        node_wdata = {NO_EDGE, LW'(0)};
      end
      S_IDLE: begin
        if (accept && cmd == CMD_CLEAR) begin
          node_we    = 1'b1;
          node_wdata = {NO_EDGE, LW'(0)};
        end
        trans_raddr = {cursor, CHW'(symbol)};
      end
      S_CLR: begin
        trans_we    = 1'b1;
        trans_waddr = {clr_row, idx_lo};
      end
      S_W1_RD, S_W2_RD: begin
        trans_raddr = {v, ch};
        node_raddr  = v;
      end
      S_W1_CHK: begin
        if (trans_q == NO_EDGE) begin
          trans_we    = 1'b1;
          trans_waddr = {v, ch};
          trans_wdata = SW'(cur);
        end else begin
          node_raddr = trans_q[IW-1:0];
        end
      end
      S_U_CHK: begin
        if (nd_len != vlen_inc) begin
          node_we    = 1'b1;
          node_waddr = count[IW-1:0];
          node_wdata = {nd_link, vlen_inc};
        end
      end
      S_CP: begin
        trans_raddr = {u, idx_lo};
        if (idx != '0) begin
          trans_we    = 1'b1;
          trans_waddr = {cl, idx_m1};
          trans_wdata = trans_q;
        end
      end
      S_U_LINK: begin
        node_we    = 1'b1;
        node_waddr = u;
        node_wdata = {SW'(cl), ulen};
      end
      S_W2_CHK: begin
        if (trans_q == SW'(u)) begin
          trans_we    = 1'b1;
          trans_waddr = {v, ch};
          trans_wdata = SW'(cl);
        end
      end
      S_FIN: begin
        node_we    = 1'b1;
        node_waddr = cur;
        node_wdata = {link_cur, cur_len};
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      count    <= SW'(1);
      last_st  <= '0;
      last_len <= '0;
      cursor   <= '0;
      qmiss    <= 1'b0;
      ovf      <= 1'b0;
      clr_row  <= '0;
      clr_ret  <= S_IDLE;
      idx      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          clr_row <= '0;
          clr_ret <= S_IDLE;
          idx     <= '0;
        end
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_CLEAR: begin
                count    <= SW'(1);
                last_st  <= '0;
                last_len <= '0;
                cursor   <= '0;
                qmiss    <= 1'b0;
                ovf      <= 1'b0;
                clr_row  <= '0;
                clr_ret  <= S_IDLE;
                idx      <= '0;
              end
              CMD_APPEND: begin
                if (sym_ok) begin
                  if (last_len >= LW'(MAX_TEXT)) begin
                    ovf <= 1'b1;
                  end else begin
                    cur     <= count[IW-1:0];
                    clr_row <= count[IW-1:0];
                    count   <= SW'(count + 1'b1);
                    v       <= last_st;
                    ch      <= CHW'(symbol);
                    clr_ret <= S_W1_RD;
                    idx     <= '0;
                  end
                end
              end
              CMD_QUERY: begin
                qbad <= !sym_ok;
                qfin <= last;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: idx <= CW'(idx + 1'b1);
        S_W1_CHK: begin
          if (trans_q == NO_EDGE) begin
            if (nd_link == NO_EDGE) link_cur <= '0;
            else v <= nd_link[IW-1:0];
          end else begin
            u    <= trans_q[IW-1:0];
            vlen <= nd_len;
          end
        end
        S_U_CHK: begin
          if (nd_len == vlen_inc) begin
            link_cur <= SW'(u);
          end else begin
            cl    <= count[IW-1:0];
            count <= SW'(count + 1'b1);
            ulen  <= nd_len;
            idx   <= '0;
          end
        end
        S_CP: idx <= CW'(idx + 1'b1);
        S_U_LINK: link_cur <= SW'(cl);
        S_W2_CHK: begin
          if (trans_q == SW'(u) && nd_link != NO_EDGE) v <= nd_link[IW-1:0];
        end
        S_FIN: begin
          last_st  <= cur;
          last_len <= cur_len;
        end
        S_Q_CHK: begin
          if (qfin) begin
            done     <= 1'b1;
            found    <= !miss_next;
            overflow <= ovf;
            cursor   <= '0;
            qmiss    <= 1'b0;
          end else begin
            qmiss <= miss_next;
            if (!miss_next) cursor <= trans_q[IW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/sam_checker.sv -----
// checker: port level timing properties of the suffix automaton core
module sam_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] cmd,
  input logic       last,
  input logic       done
);
  import sam_pkg::*;

  // a final query letter yields its result once S_Q_CHK has registered it
  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_QUERY && last) |=> ##1 done)
    else $error("query result missing");

  // a result comes only out of a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work");

  // results never come in consecutive cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("repeated result");

  // clear items keep the core busy afterwards
  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_CLEAR) |=> busy)
    else $error("clear not taken");

endmodule

bind suffix_automaton_substring_query_core sam_checker u_sam_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .cmd  (cmd),
  .last (last),
  .done (done)
);

// ----- tb/suffix_automaton_substring_query_core_test.sv -----
// testbench: suffix automaton core driven with text and query transfers, checked by a predictor
module suffix_automaton_substring_query_core_test;
  import sam_pkg::*;

  localparam int MAX_TEXT  = 1024;
  localparam int ALPHABET  = 26;
  localparam int N_STATES  = 2 * MAX_TEXT;
  localparam int NO_EDGE   = N_STATES;
  localparam int STALL_LIM = 40000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic found;
    logic overflow;
  } answer_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] cmd;
  logic [4:0] symbol;
  logic       last;
  logic       done;
  logic       found;
  logic       overflow;

  suffix_automaton_substring_query_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .symbol(symbol),
    .last(last), .done(done), .found(found), .overflow(overflow)
  );

  // predictor state of the automaton
  int         edge_to [N_STATES * ALPHABET];
  int         link_of [N_STATES];
  int         len_of  [N_STATES];
  int         n_states;
  int         tail_state;
  int         walk_pos;
  bit         walk_missed;
  bit         text_dropped;
  logic [4:0] text_q[$];

  answer_t    answer_q[$];
  int         n_sent;
  int         n_answers;
  int         n_found;
  int         n_errors;
  int         quiet_cycles;
  bit         gaps_on;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic blank_row(input int st);
    for (int i = 0; i < ALPHABET; i++) edge_to[st * ALPHABET + i] = NO_EDGE;
  endtask

  task automatic restart_text();
    blank_row(0);
    link_of[0] = NO_EDGE;
    len_of[0] = 0;
    n_states = 1;
    tail_state = 0;
    walk_pos = 0;
    walk_missed = 1'b0;
    text_dropped = 1'b0;
    text_q.delete();
  endtask

  // online extension by one letter, with cloning when a split is needed
  task automatic extend_text(input int ch);
    int  cur;
    int  v;
    int  u;
    int  cl;
    bit  alive;
    cur = n_states++;
    v = tail_state;
    alive = 1'b1;
    len_of[cur] = len_of[tail_state] + 1;
    blank_row(cur);
    while (alive && edge_to[v * ALPHABET + ch] == NO_EDGE) begin
      edge_to[v * ALPHABET + ch] = cur;
      if (link_of[v] == NO_EDGE) alive = 1'b0;
      else v = link_of[v];
    end
    if (!alive) begin
      link_of[cur] = 0;
    end else begin
      u = edge_to[v * ALPHABET + ch];
      if (len_of[u] == len_of[v] + 1) begin
        link_of[cur] = u;
      end else begin
        cl = n_states++;
        len_of[cl] = len_of[v] + 1;
        link_of[cl] = link_of[u];
        for (int i = 0; i < ALPHABET; i++)
          edge_to[cl * ALPHABET + i] = edge_to[u * ALPHABET + i];
        while (alive && edge_to[v * ALPHABET + ch] == u) begin
          edge_to[v * ALPHABET + ch] = cl;
          if (link_of[v] == NO_EDGE) alive = 1'b0;
          else v = link_of[v];
        end
        link_of[u] = cl;
        link_of[cur] = cl;
      end
    end
    tail_state = cur;
  endtask

  // apply one accepted transfer to the predictor
  task automatic predict(input logic [1:0] c, input logic [4:0] s, input logic l);
    int nx;
    answer_t a;
    case (c)
      CMD_CLEAR: restart_text();
      CMD_APPEND: begin
        if (s < ALPHABET) begin
          if (len_of[tail_state] >= MAX_TEXT) begin
            text_dropped = 1'b1;
          end else begin
            extend_text(int'(s));
            text_q.push_back(s);
          end
        end
      end
      CMD_QUERY: begin
        if (!walk_missed) begin
          if (s >= ALPHABET) begin
            walk_missed = 1'b1;
          end else begin
            nx = edge_to[walk_pos * ALPHABET + s];
            if (nx == NO_EDGE) walk_missed = 1'b1;
            else walk_pos = nx;
          end
        end
        if (l) begin
          a.found = !walk_missed;
          a.overflow = text_dropped;
          answer_q.push_back(a);
          walk_pos = 0;
          walk_missed = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // one input transfer; start stays high into the next call unless a gap is taken
  task automatic send(input logic [1:0] c, input logic [4:0] s, input logic l);
    while (gaps_on && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    symbol <= s;
    last <= l;
    do @(posedge clk); while (busy);
    predict(c, s, l);
    n_sent++;
  endtask

  task automatic send_query(input logic [4:0] pat[$]);
    foreach (pat[i]) send(CMD_QUERY, pat[i], i == pat.size() - 1);
  endtask

  task automatic send_word(input logic [4:0] w[$]);
    foreach (w[i]) send(CMD_APPEND, w[i], 1'($urandom_range(1)));
  endtask

  // settle until every answer has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && done) begin
      n_answers++;
      if (answer_q.size() == 0) begin
        $error("unexpected result found=%0b overflow=%0b", found, overflow);
        n_errors++;
      end else begin
        if (found !== answer_q[0].found) begin
          $error("found: expected %0b actual %0b", answer_q[0].found, found);
          n_errors++;
        end
        if (overflow !== answer_q[0].overflow) begin
          $error("overflow: expected %0b actual %0b", answer_q[0].overflow, overflow);
          n_errors++;
        end
        if (answer_q[0].found) n_found++;
        void'(answer_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // empty text, extremes, unused command, out-of-alphabet letters, clear mid-query
  task automatic test_directed();
    send_query('{5'd0});
    send_query('{5'd25, 5'd0});
    send_word('{5'd0, 5'd1, 5'd2, 5'd0, 5'd1, 5'd25});
    send(CMD_APPEND, 5'd31, 1'b1);
    send(CMD_APPEND, 5'd26, 1'b0);
    send(CMD_UNUSED, 5'd31, 1'b1);
    send_query('{5'd0, 5'd1});
    send_query('{5'd1, 5'd2, 5'd0, 5'd1, 5'd25});
    send_query('{5'd25});
    send_query('{5'd2, 5'd2});
    send_query('{5'd30, 5'd0});
    send_query('{5'd0, 5'd31});
    send(CMD_QUERY, 5'd0, 1'b0);
    send(CMD_CLEAR, 5'd21, 1'b1);
    send_query('{5'd0});
    drain();
  endtask

  // fill past capacity so letters are dropped, then clear
  task automatic test_text_full();
    for (int i = 0; i < MAX_TEXT + 6; i++)
      send(CMD_APPEND, 5'($urandom_range(1)), 1'b0);
    send_query('{5'd0, 5'd1, 5'd0});
    send_query('{5'd2});
    send(CMD_CLEAR, 5'd0, 1'b0);
    send_query('{5'd0});
    drain();
  endtask

  // random texts with queries mostly cut from the text itself
  task automatic test_random(input int n_items);
    logic [4:0] pat[$];
    int first;
    int len;
    int k;
    while (n_sent < n_items) begin
      gaps_on = (n_sent % 400) >= 100;
      k = $urandom_range(99);
      if (k < 5 || text_q.size() > 80) begin
        send(CMD_CLEAR, 5'($urandom_range(31)), 1'($urandom_range(1)));
      end else if (k < 40) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send(CMD_APPEND, 5'((k < 30) ? $urandom_range(2) : $urandom_range(31)),
               1'($urandom_range(1)));
      end else if (k < 43) begin
        send(CMD_UNUSED, 5'($urandom_range(31)), 1'($urandom_range(1)));
      end else begin
        pat.delete();
        len = $urandom_range(1, 8);
        if (k < 80 && text_q.size() > 0) begin
          first = $urandom_range(text_q.size() - 1);
          for (int i = first; i < text_q.size() && i < first + len; i++)
            pat.push_back(text_q[i]);
          if (k < 50) pat[$urandom_range(pat.size() - 1)] = 5'($urandom_range(31));
        end else begin
          for (int i = 0; i < len; i++)
            pat.push_back(5'((k < 95) ? $urandom_range(2) : $urandom_range(31)));
        end
        send_query(pat);
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_CLEAR;
    symbol = '0;
    last = 1'b0;
    n_sent = 0;
    n_answers = 0;
    n_found = 0;
    n_errors = 0;
    gaps_on = 1'b1;
    restart_text();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_text_full();
    test_random(1250);
    repeat (20) @(posedge clk);
    $display("covered %0d input transfers and %0d query answers (%0d found)",
             n_sent, n_answers, n_found);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
